### rtl/cdps_pkg.sv
// ----------------------------------------------------------------------------
// cdps_pkg
// Shared types and constants for the cascaded counter divisor pair search.
// ----------------------------------------------------------------------------
package cdps_pkg;

  // Shared divider width: covers 2*root + target (34 bits)
  localparam int unsigned DivW    = 34;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // Smallest divisor either counter may take
  localparam logic [15:0] MinDiv = 16'd2;

  // Request to the shared divider
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  // One finished result
  typedef struct packed {
    logic [15:0] high_divisor;
    logic [15:0] low_divisor;
    logic [31:0] actual_hz;
    logic        output_off;
  } res_t;

endpackage

### rtl/cdps_div.sv
// ----------------------------------------------------------------------------
// cdps_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all
// divisions of the search.
// ----------------------------------------------------------------------------
module cdps_div
  import cdps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]   quo_q;
  logic [DivW-1:0]   rem_q;
  logic [DivW-1:0]   den_q;

  logic [DivW:0]     shifted;
  logic [DivW:0]     diff;
  logic              ge;
  logic [DivW-1:0]   rem_d;

  // One restoring step: shift in next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});
  assign rem_d   = ge ? diff[DivW-1:0] : shifted[DivW-1:0];

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.divisor;
      quo_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### rtl/cdps_ctrl.sv
// ----------------------------------------------------------------------------
// cdps_ctrl
// Search sequencer: total divisor, integer square root, then a walk of the
// low divisor downwards using the shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
module cdps_ctrl
  import cdps_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] target_i,
  input  logic [31:0] root_i,
  output logic        idle_o,
  output logic        res_valid_o,
  input  logic        res_take_i,
  output res_t        res_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i
);

  localparam logic [32:0] MaxDiv = (33'd1 << COUNTER_BITS) - 33'd1;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_TOTAL    = 9'b000000010,
    ST_SQ_MUL   = 9'b000000100,
    ST_SQ_CMP   = 9'b000001000,
    ST_HIGH_DIV = 9'b000010000,
    ST_PROD_MUL = 9'b000100000,
    ST_ACT_DIV  = 9'b001000000,
    ST_EVAL     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]             target_q;
  logic [31:0]             total_q;
  logic [15:0]             sq_r_q;
  logic [3:0]              sq_bit_q;
  logic [31:0]             sq_prod_q;
  logic [15:0]             low_q;
  logic [31:0]             high_q;
  logic [31:0]             act_q;
  logic [COUNTER_BITS-1:0] best_hi_q;
  logic [15:0]             best_lo_q;
  logic [31:0]             best_act_q;
  logic [31:0]             min_err_q;
  logic                    have_q;
  logic                    off_q;

  logic [15:0] sq_t;
  logic [15:0] sq_r_new;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic [31:0] err;
  logic        high_over;

  // Square root trial value and its outcome
  assign sq_t     = sq_r_q | (16'd1 << sq_bit_q);
  assign sq_r_new = (sq_prod_q <= total_q) ? sq_t : sq_r_q;

  // Shared multiplier: trial square or candidate product
  always_comb begin
    mul_a = high_q;
    mul_b = low_q;
    if (state_q == ST_SQ_MUL) begin
      mul_a = 32'(sq_t);
      mul_b = sq_t;
    end
  end
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  // Absolute error of the candidate
  assign err = (target_q > act_q) ? (target_q - act_q) : (act_q - target_q);

  assign high_over = ({1'b0, div_rsp_i.quotient[31:0]} > MaxDiv);

  // Divider requests
  always_comb begin
    div_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i && (target_i != 32'd0)) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = DivW'({root_i, 1'b0}) + DivW'(target_i);
          div_req_o.divisor  = DivW'({target_i, 1'b0});
        end
      end
      ST_SQ_CMP: begin
        if (sq_bit_q == 4'd0) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = DivW'(total_q);
          div_req_o.divisor  = DivW'(sq_r_new);
        end
      end
      ST_PROD_MUL: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivW'(root_i);
        div_req_o.divisor  = DivW'(mul_p[31:0]);
      end
      ST_EVAL: begin
        if ((err != 32'd0) && (low_q != MinDiv)) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = DivW'(total_q);
          div_req_o.divisor  = DivW'(low_q - 16'd1);
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (target_i == 32'd0) ? ST_DONE : ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        if (div_rsp_i.done) begin
          state_d = (div_rsp_i.quotient[31:0] <= 32'd4) ? ST_DONE : ST_SQ_MUL;
        end
      end
      ST_SQ_MUL:   state_d = ST_SQ_CMP;
      ST_SQ_CMP:   state_d = (sq_bit_q == 4'd0) ? ST_HIGH_DIV : ST_SQ_MUL;
      ST_HIGH_DIV: begin
        if (div_rsp_i.done) begin
          state_d = high_over ? ST_DONE : ST_PROD_MUL;
        end
      end
      ST_PROD_MUL: state_d = ST_ACT_DIV;
      ST_ACT_DIV: begin
        if (div_rsp_i.done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ((err == 32'd0) || (low_q == MinDiv)) ? ST_DONE : ST_HIGH_DIV;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          target_q <= target_i;
          have_q   <= 1'b0;
          if (target_i == 32'd0) begin
            off_q      <= 1'b1;
            best_hi_q  <= '0;
            best_lo_q  <= '0;
            best_act_q <= '0;
          end else begin
            off_q      <= 1'b0;
            best_hi_q  <= COUNTER_BITS'(MinDiv);
            best_lo_q  <= MinDiv;
            best_act_q <= root_i >> 2;
          end
        end
      end
      ST_TOTAL: begin
        if (div_rsp_i.done) begin
          total_q  <= div_rsp_i.quotient[31:0];
          sq_r_q   <= '0;
          sq_bit_q <= 4'd15;
        end
      end
      ST_SQ_MUL: sq_prod_q <= mul_p[31:0];
      ST_SQ_CMP: begin
        sq_r_q   <= sq_r_new;
        sq_bit_q <= sq_bit_q - 4'd1;
        if (sq_bit_q == 4'd0) begin
          low_q <= sq_r_new;
        end
      end
      ST_HIGH_DIV: begin
        if (div_rsp_i.done) begin
          high_q <= div_rsp_i.quotient[31:0];
        end
      end
      ST_ACT_DIV: begin
        if (div_rsp_i.done) begin
          act_q <= div_rsp_i.quotient[31:0];
        end
      end
      ST_EVAL: begin
        // First least error wins; an exact hit ends the walk
        if ((err == 32'd0) || !have_q || (err < min_err_q)) begin
          have_q     <= 1'b1;
          min_err_q  <= err;
          best_hi_q  <= high_q[COUNTER_BITS-1:0];
          best_lo_q  <= low_q;
          best_act_q <= act_q;
        end
        low_q <= low_q - 16'd1;
      end
      default: ;
    endcase
  end

  assign idle_o                = (state_q == ST_IDLE);
  assign res_valid_o           = (state_q == ST_DONE);
  assign res_o.high_divisor    = 16'(best_hi_q);
  assign res_o.low_divisor     = best_lo_q;
  assign res_o.actual_hz       = best_act_q;
  assign res_o.output_off      = off_q;

  // Divider answers only while the sequencer waits for it
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_TOTAL || state_q == ST_HIGH_DIV ||
                        state_q == ST_ACT_DIV))
    else $error("divider finished outside a wait state");

  // The walk never evaluates a low divisor below the minimum
  a_low_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (low_q >= MinDiv))
    else $error("low divisor below minimum in evaluation");

  // A live result has high >= low >= minimum
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !off_q) |->
      (best_lo_q >= MinDiv && 32'(best_hi_q) >= 32'(best_lo_q)))
    else $error("chosen divisor pair out of order");

endmodule

### rtl/clock_divisor_pair_search.sv
// ----------------------------------------------------------------------------
// clock_divisor_pair_search
// Picks two cascaded counter divisors whose product best divides the root
// clock down to the wanted frequency; holds the root clock register and the
// result register.
// ----------------------------------------------------------------------------
// Steps: target 0 yields output off directly; otherwise the total divisor,
//   its square root, then a multiply and two divisions per low divisor tried.
// Flow: one transaction at a time; the input stalls while the search runs,
//   paced by the 34-bit shared divider (one quotient bit per cycle).
// The result register frees the search for the next transaction early.
// Reset: root clock returns to 10 MHz, no result pending, search idle.
// ----------------------------------------------------------------------------
module clock_divisor_pair_search
  import cdps_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] root_clock_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] target_hz_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] high_divisor_o,
  output logic [15:0] low_divisor_o,
  output logic [31:0] actual_hz_o,
  output logic        output_off_o
);

  logic [31:0] root_clock_q;
  logic        idle;
  logic        res_valid;
  logic        res_take;
  logic        in_accept;
  res_t        res;
  res_t        out_q;
  logic        out_valid_q, out_valid_d;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Root clock register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_clock_q <= 32'd10000000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_clock_q <= root_clock_i;
    end
  end

  // Input transaction
  assign in_stall_o = !idle;
  assign in_accept  = in_valid_i && !in_stall_o;

  cdps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cdps_ctrl #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .target_i    (target_hz_i),
    .root_i      (root_clock_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  // Result register
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign high_divisor_o = out_q.high_divisor;
  assign low_divisor_o  = out_q.low_divisor;
  assign actual_hz_o    = out_q.actual_hz;
  assign output_off_o   = out_q.output_off;

endmodule
